>>> sv/vna_pkg.sv
// vna_pkg: shared types and constants of the vertex normal accumulator
// controller command and status structs, state and multiplier source codes
// no dependencies
`timescale 1ns / 1ps

package vna_pkg;

    localparam int IDX_W     = 10;
    localparam int COORD_W   = 16;
    localparam int POS_W     = 3 * COORD_W;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int CROSS_W   = 2 * EDGE_W + 1;
    localparam int SUM_W     = 44;
    localparam int SUMS_W    = 3 * SUM_W;
    localparam int MAG_LIM   = 30;
    localparam int MUL_W     = MAG_LIM + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQ_W      = 62;
    localparam int ROOT_W    = 63;
    localparam int LEN_W     = 31;
    localparam int DEN_W     = LEN_W + 1;
    localparam int QUO_W     = 15;
    localparam int UNIT_W    = 16;
    localparam int CNT_W     = 5;
    localparam int CROSS_STEPS = 6;
    localparam int SQ_STEPS    = 3;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = QUO_W;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FACE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F_RD0,
        ST_F_RD1,
        ST_F_RD2,
        ST_F_E2,
        ST_F_MUL,
        ST_F_SRD,
        ST_F_SWR,
        ST_R_RD,
        ST_R_MAG,
        ST_R_NORM,
        ST_R_SQ,
        ST_R_SQW,
        ST_R_SQRT,
        ST_R_DINIT,
        ST_R_DSTEP,
        ST_R_DEND,
        ST_R_OUT
    } t_state;

    // cross product terms first, then the three squares
    typedef enum logic [3:0] {
        MS_C0  = 4'd0,
        MS_C1  = 4'd1,
        MS_C2  = 4'd2,
        MS_C3  = 4'd3,
        MS_C4  = 4'd4,
        MS_C5  = 4'd5,
        MS_SQX = 4'd6,
        MS_SQY = 4'd7,
        MS_SQZ = 4'd8
    } t_mul_src;

    typedef struct packed {
        logic       accept;
        logic       pos_we;
        logic [1:0] pos_sel;
        logic       cap_p0;
        logic       cap_e1;
        logic       cap_e2;
        logic       mul_en;
        t_mul_src   mul_src;
        logic [1:0] sum_sel;
        logic       sum_we;
        logic       clr_init;
        logic       clr_step;
        logic       cap_mag;
        logic       shift;
        logic       sqrt_init;
        logic       sqrt_step;
        logic [1:0] comp;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_zero;
        logic need_shift;
        logic out_busy;
    } t_stat;

endpackage

>>> sv/vna_ram.sv
// vna_ram: generic single write port, single read port memory
// read data is registered; no dependencies
`timescale 1ns / 1ps

module vna_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/vna_ctrl.sv
// vna_ctrl: sequencer for load, face, read and clear items
// depends on vna_pkg for state, command and status types
`timescale 1ns / 1ps

module vna_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_kind,
    input  vna_pkg::t_stat i_stat,
    output vna_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);

    import vna_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_k, n_k;
    t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        cmd     = '0;
        case (r_state)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    case (t_kind'(i_kind))
                        KIND_LOAD:  cmd.pos_we = 1'b1;
                        KIND_FACE:  n_state = ST_F_RD0;
                        KIND_READ:  n_state = ST_R_RD;
                        KIND_CLEAR: begin
                            cmd.clr_init = 1'b1;
                            n_state      = ST_CLEAR;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_F_RD0: begin
                cmd.pos_sel = 2'd0;
                n_state     = ST_F_RD1;
            end
            ST_F_RD1: begin
                cmd.pos_sel = 2'd1;
                cmd.cap_p0  = 1'b1;
                n_state     = ST_F_RD2;
            end
            ST_F_RD2: begin
                cmd.pos_sel = 2'd2;
                cmd.cap_e1  = 1'b1;
                n_state     = ST_F_E2;
            end
            ST_F_E2: begin
                cmd.cap_e2 = 1'b1;
                n_cnt      = '0;
                n_state    = ST_F_MUL;
            end
            ST_F_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = t_mul_src'(r_cnt[3:0]);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CROSS_STEPS - 1)) begin
                    n_k     = '0;
                    n_state = ST_F_SRD;
                end
            end
            ST_F_SRD: begin
                cmd.sum_sel = r_k;
                n_state     = ST_F_SWR;
            end
            ST_F_SWR: begin
                cmd.sum_sel = r_k;
                cmd.sum_we  = 1'b1;
                if (r_k == 2'd2) begin
                    n_state = ST_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_F_SRD;
                end
            end
            ST_R_RD: begin
                cmd.sum_sel = 2'd0;
                n_state     = ST_R_MAG;
            end
            ST_R_MAG: begin
                cmd.cap_mag = 1'b1;
                n_state     = ST_R_NORM;
            end
            ST_R_NORM: begin
                if (i_stat.is_zero) begin
                    n_state = ST_R_OUT;
                end else if (i_stat.need_shift) begin
                    cmd.shift = 1'b1;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_R_SQ;
                end
            end
            ST_R_SQ: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = t_mul_src'(r_cnt[3:0] + 4'(MS_SQX));
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_state = ST_R_SQW;
                end
            end
            ST_R_SQW: begin
                cmd.sqrt_init = 1'b1;
                n_cnt         = '0;
                n_state       = ST_R_SQRT;
            end
            ST_R_SQRT: begin
                cmd.sqrt_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_k     = '0;
                    n_state = ST_R_DINIT;
                end
            end
            ST_R_DINIT: begin
                cmd.comp     = r_k;
                cmd.div_init = 1'b1;
                n_cnt        = '0;
                n_state      = ST_R_DSTEP;
            end
            ST_R_DSTEP: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_R_DEND;
                end
            end
            ST_R_DEND: begin
                cmd.comp      = r_k;
                cmd.div_store = 1'b1;
                if (r_k == 2'd2) begin
                    n_state = ST_R_OUT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_R_DINIT;
                end
            end
            ST_R_OUT: begin
                if (!i_stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

>>> sv/vna_datapath.sv
// vna_datapath: position and sum memories, cross product, saturating sums,
// shift, square root and divide units, output register; depends on vna_pkg, vna_ram
`timescale 1ns / 1ps

module vna_datapath #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vna_pkg::t_cmd                       i_cmd,
    output vna_pkg::t_stat                      o_stat,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_a,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_b,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_c,
    input  logic [vna_pkg::IDX_W-1:0]           i_normal_a,
    input  logic [vna_pkg::IDX_W-1:0]           i_normal_b,
    input  logic [vna_pkg::IDX_W-1:0]           i_normal_c,
    input  logic signed [vna_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [vna_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [vna_pkg::COORD_W-1:0]  i_pos_z,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [vna_pkg::UNIT_W-1:0]   o_unit_x,
    output logic signed [vna_pkg::UNIT_W-1:0]   o_unit_y,
    output logic signed [vna_pkg::UNIT_W-1:0]   o_unit_z,
    output logic                                o_zero_length,
    output logic                                o_overflowed
);

    import vna_pkg::*;

    localparam int AW      = $clog2(VERTEX_SLOTS);
    localparam int RED_SH  = 24;
    localparam int RECIP   = (1 << RED_SH) / VERTEX_SLOTS + 1;
    localparam int RECIP_W = RED_SH;
    localparam int PRD_W   = IDX_W + RECIP_W;
    localparam int RED_W   = IDX_W + 17;

    // index modulo slot count by reciprocal multiply and one correction
    function automatic logic [AW-1:0] f_slot(input logic [IDX_W-1:0] v);
        logic [PRD_W-1:0] prod;
        logic [IDX_W-1:0] q;
        logic [RED_W-1:0] r;
        prod = PRD_W'(v) * PRD_W'(RECIP);
        q    = prod[RED_SH +: IDX_W];
        r    = RED_W'(v) - RED_W'(q) * RED_W'(VERTEX_SLOTS);
        if (r >= RED_W'(VERTEX_SLOTS)) begin
            r = r - RED_W'(VERTEX_SLOTS);
        end
        return r[AW-1:0];
    endfunction

    logic [AW-1:0] r_vtx [3];
    logic [AW-1:0] r_nrm [3];

    logic [POS_W-1:0]  pos_rd;
    logic [SUMS_W-1:0] sum_rd;
    logic [SUMS_W-1:0] sum_wd;
    logic [AW-1:0]     sum_slot;
    logic [AW-1:0]     r_clr_addr;

    logic signed [COORD_W-1:0] r_p0 [3];
    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [CROSS_W-1:0] r_n  [3];

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] r_prod;
    t_mul_src                 r_prod_src;
    logic                     r_prod_vld;

    logic [SUM_W-1:0] r_mag [3];
    logic             r_neg [3];
    logic [SQ_W-1:0]  r_nsq;
    logic [ROOT_W-1:0] r_res, r_bit;
    logic [ROOT_W:0]  sq_trial;

    logic [DEN_W-1:0]   den;
    logic [DEN_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_num;
    logic [QUO_W-1:0]   r_q;
    logic [DEN_W:0]     div_trial;
    logic [DEN_W:0]     div_diff;
    logic [MAG_LIM+QUO_W:0] div_n;
    logic [SUM_W-1:0]   div_m;

    logic signed [UNIT_W-1:0] r_unit [3];
    logic                     r_sat;
    logic [2:0]               ovf;
    logic                     is_zero;
    logic                     r_out_valid;
    logic signed [UNIT_W-1:0] r_out_x, r_out_y, r_out_z;
    logic                     r_out_zero, r_out_ovf;

    function automatic logic signed [COORD_W-1:0] f_coord(
        input logic [POS_W-1:0] p, input int c);
        return p[POS_W-1-COORD_W*c -: COORD_W];
    endfunction

    // item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_vtx[0] <= f_slot(i_vertex_a);
            r_vtx[1] <= f_slot(i_vertex_b);
            r_vtx[2] <= f_slot(i_vertex_c);
            r_nrm[0] <= f_slot(i_normal_a);
            r_nrm[1] <= f_slot(i_normal_b);
            r_nrm[2] <= f_slot(i_normal_c);
        end
    end

    vna_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_SLOTS)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.pos_we),
        .i_waddr(f_slot(i_vertex_a)),
        .i_wdata({i_pos_x, i_pos_y, i_pos_z}),
        .i_raddr(r_vtx[i_cmd.pos_sel]),
        .o_rdata(pos_rd)
    );

    // corner edges
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.cap_p0) begin
                r_p0[c] <= f_coord(pos_rd, c);
            end
            if (i_cmd.cap_e1) begin
                r_e1[c] <= EDGE_W'(f_coord(pos_rd, c)) - EDGE_W'(r_p0[c]);
            end
            if (i_cmd.cap_e2) begin
                r_e2[c] <= EDGE_W'(f_coord(pos_rd, c)) - EDGE_W'(r_p0[c]);
            end
        end
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_src)
            MS_C0: begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[2]); end
            MS_C1: begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[1]); end
            MS_C2: begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[0]); end
            MS_C3: begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[2]); end
            MS_C4: begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[1]); end
            MS_C5: begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[0]); end
            MS_SQX: begin
                mul_a = {1'b0, r_mag[0][MAG_LIM-1:0]};
                mul_b = {1'b0, r_mag[0][MAG_LIM-1:0]};
            end
            MS_SQY: begin
                mul_a = {1'b0, r_mag[1][MAG_LIM-1:0]};
                mul_b = {1'b0, r_mag[1][MAG_LIM-1:0]};
            end
            MS_SQZ: begin
                mul_a = {1'b0, r_mag[2][MAG_LIM-1:0]};
                mul_b = {1'b0, r_mag[2][MAG_LIM-1:0]};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
        r_prod     <= mul_a * mul_b;
        r_prod_src <= i_cmd.mul_src;
    end

    assign sq_trial = {1'b0, r_res} + {1'b0, r_bit};

    // product accumulation and square root share the sum of squares register
    always_ff @(posedge i_clk) begin
        if (r_prod_vld) begin
            case (r_prod_src)
                MS_C0:  r_n[0] <= r_prod[CROSS_W-1:0];
                MS_C1:  r_n[0] <= r_n[0] - r_prod[CROSS_W-1:0];
                MS_C2:  r_n[1] <= r_prod[CROSS_W-1:0];
                MS_C3:  r_n[1] <= r_n[1] - r_prod[CROSS_W-1:0];
                MS_C4:  r_n[2] <= r_prod[CROSS_W-1:0];
                MS_C5:  r_n[2] <= r_n[2] - r_prod[CROSS_W-1:0];
                MS_SQX: r_nsq  <= r_prod[SQ_W-1:0];
                MS_SQY, MS_SQZ: r_nsq <= r_nsq + r_prod[SQ_W-1:0];
                default: r_nsq <= r_nsq;
            endcase
        end else if (i_cmd.sqrt_step) begin
            if ({2'b00, r_nsq} >= sq_trial) begin
                r_nsq <= r_nsq - sq_trial[SQ_W-1:0];
            end
        end
        if (i_cmd.sqrt_init) begin
            r_res <= '0;
            r_bit <= ROOT_W'(1) << (ROOT_W - 1);
        end else if (i_cmd.sqrt_step) begin
            if ({2'b00, r_nsq} >= sq_trial) begin
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // sum memory: x, y, z sums side by side
    assign sum_slot = r_nrm[i_cmd.sum_sel];

    always_comb begin
        logic signed [SUM_W:0] wide;
        for (int c = 0; c < 3; c++) begin
            wide = {sum_rd[SUMS_W-1-SUM_W*c], sum_rd[SUMS_W-1-SUM_W*c -: SUM_W]}
                 + (SUM_W+1)'(r_n[c]);
            ovf[c] = (wide[SUM_W] != wide[SUM_W-1]);
            if (ovf[c]) begin
                sum_wd[SUMS_W-1-SUM_W*c -: SUM_W] = wide[SUM_W]
                    ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sum_wd[SUMS_W-1-SUM_W*c -: SUM_W] = wide[SUM_W-1:0];
            end
        end
    end

    vna_ram #(.WIDTH(SUMS_W), .DEPTH(VERTEX_SLOTS)) u_sum_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.sum_we | i_cmd.clr_step),
        .i_waddr(i_cmd.clr_step ? r_clr_addr : sum_slot),
        .i_wdata(i_cmd.clr_step ? '0 : sum_wd),
        .i_raddr(sum_slot),
        .o_rdata(sum_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_sat      <= 1'b0;
        end else begin
            if (i_cmd.clr_init) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.clr_init) begin
                r_sat <= 1'b0;
            end else if (i_cmd.sum_we && (ovf != 3'b000)) begin
                r_sat <= 1'b1;
            end
        end
    end

    // magnitudes and range reduction
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.cap_mag) begin
                r_neg[c] <= sum_rd[SUMS_W-1-SUM_W*c];
                r_mag[c] <= sum_rd[SUMS_W-1-SUM_W*c]
                    ? SUM_W'(0) - sum_rd[SUMS_W-1-SUM_W*c -: SUM_W]
                    : sum_rd[SUMS_W-1-SUM_W*c -: SUM_W];
            end else if (i_cmd.shift) begin
                r_mag[c] <= r_mag[c] >> 1;
            end
        end
    end

    assign is_zero = ((r_mag[0] | r_mag[1] | r_mag[2]) == '0);

    // rounded quotient m * 16384 / len, one bit a cycle
    assign den       = {r_res[LEN_W-1:0], 1'b0};
    assign div_m     = r_mag[i_cmd.comp];
    assign div_n     = {1'b0, div_m[MAG_LIM-1:0], {QUO_W{1'b0}}}
                     + (MAG_LIM+QUO_W+1)'(r_res[LEN_W-1:0]);
    assign div_trial = {r_rem, r_num[QUO_W-1]};
    assign div_diff  = div_trial - {1'b0, den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= DEN_W'(div_n[MAG_LIM+QUO_W:QUO_W]);
            r_num <= div_n[QUO_W-1:0];
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            if (div_trial >= {1'b0, den}) begin
                r_rem <= div_diff[DEN_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= div_trial[DEN_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_store) begin
            r_unit[i_cmd.comp] <= r_neg[i_cmd.comp]
                ? UNIT_W'(0) - {1'b0, r_q} : {1'b0, r_q};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_x    <= is_zero ? '0 : r_unit[0];
            r_out_y    <= is_zero ? '0 : r_unit[1];
            r_out_z    <= is_zero ? '0 : r_unit[2];
            r_out_zero <= is_zero;
            r_out_ovf  <= r_sat;
        end
    end

    assign o_stat.clr_last   = (r_clr_addr == AW'(VERTEX_SLOTS - 1));
    assign o_stat.is_zero    = is_zero;
    assign o_stat.need_shift = ((r_mag[0] | r_mag[1] | r_mag[2]) >> MAG_LIM) != '0;
    assign o_stat.out_busy   = r_out_valid & i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_unit_x      = r_out_x;
    assign o_unit_y      = r_out_y;
    assign o_unit_z      = r_out_z;
    assign o_zero_length = r_out_zero;
    assign o_overflowed  = r_out_ovf;

endmodule

>>> sv/vertex_normal_accumulator.sv
// vertex_normal_accumulator: area-weighted smooth vertex normals in fixed point
// a load writes one position entry; a face does three table reads, six products on one
// multiplier and three read-modify-writes; a read does a 32-step root, three 15-step
// divides and up to 14 shifts, and a zero-length read skips the root and the divides
// after reset and after each clear item the sum memory is swept to zero with input
// stalled; result register frees the input side
`timescale 1ns / 1ps

module vertex_normal_accumulator #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_a,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_b,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_c,
    input  logic [vna_pkg::IDX_W-1:0]           i_normal_a,
    input  logic [vna_pkg::IDX_W-1:0]           i_normal_b,
    input  logic [vna_pkg::IDX_W-1:0]           i_normal_c,
    input  logic signed [vna_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [vna_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [vna_pkg::COORD_W-1:0]  i_pos_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [vna_pkg::UNIT_W-1:0]   o_unit_x,
    output logic signed [vna_pkg::UNIT_W-1:0]   o_unit_y,
    output logic signed [vna_pkg::UNIT_W-1:0]   o_unit_z,
    output logic                                o_zero_length,
    output logic                                o_overflowed
);

    import vna_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    vna_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_kind    (i_kind),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    vna_datapath #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .i_vertex_c   (i_vertex_c),
        .i_normal_a   (i_normal_a),
        .i_normal_b   (i_normal_b),
        .i_normal_c   (i_normal_c),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_unit_x     (o_unit_x),
        .o_unit_y     (o_unit_y),
        .o_unit_z     (o_unit_z),
        .o_zero_length(o_zero_length),
        .o_overflowed (o_overflowed)
    );

endmodule

>>> tb/tb_vertex_normal_accumulator.sv
// tb_vertex_normal_accumulator: self-checking bench for the vertex normal accumulator
// predicts normals, overflow and zero-length flags from its own sum stores
// depends on vna_pkg and vertex_normal_accumulator
`timescale 1ns / 1ps

module tb_vertex_normal_accumulator;
    import vna_pkg::*;

    localparam longint SUM_HI = 64'sd8796093022207;
    localparam longint SUM_LO = -64'sd8796093022208;

    typedef struct {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic               zl;
        logic               ovf;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic [1:0] kind = KIND_LOAD;
    logic [9:0] va = '0, vb = '0, vc = '0, na = '0, nb = '0, nc = '0;
    logic signed [15:0] px = '0, py = '0, pz = '0;
    logic out_valid, zero_length, overflowed;
    logic signed [15:0] unit_x, unit_y, unit_z;

    vertex_normal_accumulator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_vertex_a(va), .i_vertex_b(vb), .i_vertex_c(vc),
        .i_normal_a(na), .i_normal_b(nb), .i_normal_c(nc),
        .i_pos_x(px), .i_pos_y(py), .i_pos_z(pz),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_unit_x(unit_x), .o_unit_y(unit_y), .o_unit_z(unit_z),
        .o_zero_length(zero_length), .o_overflowed(overflowed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    longint pos_tab [1024][3];
    bit     pos_written [1024];
    longint acc_x [1024], acc_y [1024], acc_z [1024];
    bit     sat_seen;
    t_normal normals_due [$];
    int errors = 0;
    int burst_left = 0;

    function automatic longint sat_sum(longint s, longint d);
        longint r;
        r = s + d;
        if (r > SUM_HI) begin
            sat_seen = 1'b1;
            return SUM_HI;
        end
        if (r < SUM_LO) begin
            sat_seen = 1'b1;
            return SUM_LO;
        end
        return r;
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] unit_of(longint v, longint unsigned m,
                                            longint unsigned len);
        longint unsigned q;
        q = (m * 32768 + len) / (2 * len);
        return (v < 0) ? -q[15:0] : q[15:0];
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    task automatic predict_beat(logic [1:0] k);
        longint e1 [3], e2 [3], n [3];
        longint unsigned mx, my, mz, mm, len;
        int s;
        t_normal r;
        case (k)
            KIND_LOAD: begin
                pos_tab[va][0] = px;
                pos_tab[va][1] = py;
                pos_tab[va][2] = pz;
                pos_written[va] = 1'b1;
            end
            KIND_FACE: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = pos_tab[vb][i] - pos_tab[va][i];
                    e2[i] = pos_tab[vc][i] - pos_tab[va][i];
                end
                n[0] = e1[1] * e2[2] - e1[2] * e2[1];
                n[1] = e1[2] * e2[0] - e1[0] * e2[2];
                n[2] = e1[0] * e2[1] - e1[1] * e2[0];
                for (int i = 0; i < 3; i++) begin
                    s = (i == 0) ? na : (i == 1) ? nb : nc;
                    acc_x[s] = sat_sum(acc_x[s], n[0]);
                    acc_y[s] = sat_sum(acc_y[s], n[1]);
                    acc_z[s] = sat_sum(acc_z[s], n[2]);
                end
            end
            KIND_CLEAR: begin
                foreach (acc_x[i]) begin
                    acc_x[i] = 0;
                    acc_y[i] = 0;
                    acc_z[i] = 0;
                end
                sat_seen = 1'b0;
            end
            default: begin
                mx = mag(acc_x[na]);
                my = mag(acc_y[na]);
                mz = mag(acc_z[na]);
                mm = mx;
                if (my > mm) mm = my;
                if (mz > mm) mm = mz;
                r.ovf = sat_seen;
                if (mm == 0) begin
                    r.ux = 0;
                    r.uy = 0;
                    r.uz = 0;
                    r.zl = 1'b1;
                end else begin
                    while (mm >= (64'd1 << 30)) begin
                        mm >>= 1;
                        mx >>= 1;
                        my >>= 1;
                        mz >>= 1;
                    end
                    len = int_root(mx * mx + my * my + mz * mz);
                    r.ux = unit_of(acc_x[na], mx, len);
                    r.uy = unit_of(acc_y[na], my, len);
                    r.uz = unit_of(acc_z[na], mz, len);
                    r.zl = 1'b0;
                end
                normals_due = {normals_due, r};
            end
        endcase
    endtask

    // sends one beat; sender runs in bursts with random gaps
    task automatic send_beat(logic [1:0] k, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                             logic [9:0] sa, logic [9:0] sb, logic [9:0] sc,
                             logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        va <= a; vb <= b; vc <= c;
        na <= sa; nb <= sb; nc <= sc;
        px <= x; py <= y; pz <= z;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_beat(k);
    endtask

    task automatic end_traffic();
        in_valid <= 1'b0;
        burst_left = 0;
        while (normals_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_vertex(logic [9:0] a, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z);
        send_beat(KIND_LOAD, a, 10'($urandom), 10'($urandom), 10'($urandom),
                  10'($urandom), 10'($urandom), x, y, z);
    endtask

    task automatic face(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                        logic [9:0] sa, logic [9:0] sb, logic [9:0] sc);
        send_beat(KIND_FACE, a, b, c, sa, sb, sc, 16'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    task automatic read_normal(logic [9:0] s);
        send_beat(KIND_READ, 10'($urandom), 10'($urandom), 10'($urandom), s,
                  10'($urandom), 10'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic clear_sums();
        send_beat(KIND_CLEAR, 10'($urandom), 10'($urandom), 10'($urandom),
                  10'($urandom), 10'($urandom), 10'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [9:0] some_loaded();
        logic [9:0] v;
        do v = 10'($urandom); while (!pos_written[v]);
        return v;
    endfunction

    task automatic test_extremes();
        load_vertex(10'd0, 16'h8000, 16'h8000, 16'h8000);
        load_vertex(10'd1023, 16'h7fff, 16'h7fff, 16'h8000);
        load_vertex(10'd512, 16'h7fff, 16'h8000, 16'h7fff);
        load_vertex(10'd3, 16'h0000, 16'h0000, 16'h0000);
        read_normal(10'd0);
        face(10'd0, 10'd1023, 10'd512, 10'd0, 10'd1023, 10'd5);
        face(10'd0, 10'd512, 10'd1023, 10'd7, 10'd7, 10'd7);
        face(10'd3, 10'd3, 10'd0, 10'd8, 10'd8, 10'd8);
        read_normal(10'd0);
        read_normal(10'd1023);
        read_normal(10'd7);
        read_normal(10'd8);
        end_traffic();
    endtask

    // the extreme face adds about 2^32 per corner to slot 9, so a few hundred saturate
    task automatic test_saturation();
        for (int i = 0; i < 750; i++) begin
            face(10'd0, 10'd1023, 10'd512, 10'd9, 10'd9, 10'd9);
            if (i % 100 == 0) read_normal(10'd9);
        end
        read_normal(10'd9);
        read_normal(10'd100);
        clear_sums();
        read_normal(10'd9);
        end_traffic();
    endtask

    task automatic test_random_mesh();
        int pick;
        for (int i = 0; i < 1024; i += $urandom_range(2, 8))
            load_vertex(10'(i), 16'($urandom), 16'($urandom), 16'($urandom));
        for (int i = 0; i < 400; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                load_vertex(some_loaded(), 16'($urandom), 16'($urandom),
                            16'($urandom));
            else if (pick < 60)
                face(some_loaded(), some_loaded(), some_loaded(),
                     10'($urandom), 10'($urandom_range(0, 15)),
                     10'($urandom_range(0, 15)));
            else if (pick < 98)
                read_normal((pick & 1) ? 10'($urandom_range(0, 15)) : 10'($urandom));
            else
                clear_sums();
        end
        end_traffic();
    endtask

    // random receiver stall pattern
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 7) < 3) && (($urandom & 32'h100) != 0);
    end

    always @(posedge i_clk) begin
        t_normal w;
        if (i_rst_n && out_valid && !out_stall) begin
            if (normals_due.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                w = normals_due.pop_front();
                if (unit_x !== w.ux) begin
                    $error("unit_x exp %0d got %0d", w.ux, unit_x);
                    errors++;
                end
                if (unit_y !== w.uy) begin
                    $error("unit_y exp %0d got %0d", w.uy, unit_y);
                    errors++;
                end
                if (unit_z !== w.uz) begin
                    $error("unit_z exp %0d got %0d", w.uz, unit_z);
                    errors++;
                end
                if (zero_length !== w.zl) begin
                    $error("zero_length exp %0b got %0b", w.zl, zero_length);
                    errors++;
                end
                if (overflowed !== w.ovf) begin
                    $error("overflowed exp %0b got %0b", w.ovf, overflowed);
                    errors++;
                end
            end
        end
    end

    initial begin
        sat_seen = 1'b0;
        foreach (acc_x[i]) begin
            acc_x[i] = 0;
            acc_y[i] = 0;
            acc_z[i] = 0;
            pos_written[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_saturation();
        test_random_mesh();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && normals_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
